// ===== hw/rtl/cosine_similarity_vec4_unit_defines.svh =====
// Assertion macros for the cosine similarity unit.
// Needs a clk and an active-low rst_n in the scope that uses them.
`ifndef COSINE_SIMILARITY_VEC4_UNIT_DEFINES_SVH
`define COSINE_SIMILARITY_VEC4_UNIT_DEFINES_SVH

// Holds whenever the unit is out of reset.
`define CSV_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("csv assertion failed");

// Antecedent implies consequent in the same cycle.
`define CSV_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csv assertion failed");

`endif

// ===== hw/rtl/csv_pkg.sv =====
// Shared types and constants for the cosine similarity unit.
// No dependencies.
package csv_pkg;

  localparam int LANES      = 4;
  localparam int ELEM_W     = 16;
  localparam int COS_W      = 16;
  localparam int PROD_W     = 32;   // signed lane product
  localparam int SQ_W       = 31;   // unsigned square, max 2^30
  localparam int DOT_W      = 34;   // signed sum of four products
  localparam int NORM_W     = 33;   // sum of four squares, max 2^32
  localparam int NN_W       = 2 * NORM_W; // |a|^2 * |b|^2
  localparam int ROOT_W     = NORM_W;
  localparam int REM_W      = ROOT_W + 2;
  localparam int NUM_W      = NORM_W + 14; // |dot| << 14
  localparam int QUO_W      = 16;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = QUO_W;
  localparam int NORM_LAT   = 3;
  localparam int LATENCY    = 1 + NORM_LAT + SQRT_STEPS + DIV_STEPS + 1;
  localparam logic [QUO_W-1:0] COS_ONE = QUO_W'(16384);

  typedef struct packed {
    logic signed [PROD_W-1:0] dot;
    logic [SQ_W-1:0]          sqa;
    logic [SQ_W-1:0]          sqb;
  } lane_t;

  // Per-item data carried beside the root and quotient pipelines.
  typedef struct packed {
    logic [NORM_W-1:0] mag;
    logic              neg;
    logic              zero;
  } side_t;

endpackage

// ===== hw/rtl/csv_lane.sv =====
// One element lane: product and both squares of a component pair.
// Depends on csv_pkg.
module csv_lane (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [csv_pkg::ELEM_W-1:0]   a,
  input  logic signed [csv_pkg::ELEM_W-1:0]   b,
  output csv_pkg::lane_t                      lane_r
);
  import csv_pkg::*;

  logic signed [PROD_W-1:0] ab, aa, bb;
  lane_t lane_nxt;

  always_comb begin
    ab = a * b;
    aa = a * a;
    bb = b * b;
    lane_nxt.dot = ab;
    lane_nxt.sqa = aa[SQ_W-1:0];
    lane_nxt.sqb = bb[SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end
endmodule

// ===== hw/rtl/csv_norm.sv =====
// Merge of lane results: dot product, squared norms and their product.
// Depends on csv_pkg. Three register stages.
module csv_norm (
  input  logic                             clk,
  input  logic                             en,
  input  csv_pkg::lane_t                   lanes [csv_pkg::LANES],
  output logic [csv_pkg::NN_W-1:0]         prod_r,
  output csv_pkg::side_t                   side_r
);
  import csv_pkg::*;

  logic signed [DOT_W-1:0] dot_r, dot_nxt;
  logic [NORM_W-1:0]       na_r, na_nxt, nb_r, nb_nxt;
  logic [NORM_W+16:0]      p0_r, p0_nxt;   // na * nb[16:0]
  logic [NORM_W+15:0]      p1_r, p1_nxt;   // na * nb[32:17]
  side_t                   s2_r, s2_nxt;
  logic signed [DOT_W-1:0] dot_abs;

  always_comb begin
    dot_nxt = '0;
    na_nxt  = '0;
    nb_nxt  = '0;
    for (int i = 0; i < LANES; i++) begin
      dot_nxt = dot_nxt + DOT_W'(lanes[i].dot);
      na_nxt  = na_nxt + NORM_W'(lanes[i].sqa);
      nb_nxt  = nb_nxt + NORM_W'(lanes[i].sqb);
    end
  end

  always_comb begin
    dot_abs     = dot_r[DOT_W-1] ? -dot_r : dot_r;
    s2_nxt.mag  = dot_abs[NORM_W-1:0];
    s2_nxt.neg  = dot_r[DOT_W-1];
    s2_nxt.zero = (na_r == '0) || (nb_r == '0);
    p0_nxt      = (NORM_W+17)'(na_r) * (NORM_W+17)'(nb_r[16:0]);
    p1_nxt      = (NORM_W+16)'(na_r) * (NORM_W+16)'(nb_r[NORM_W-1:17]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot_r  <= dot_nxt;
      na_r   <= na_nxt;
      nb_r   <= nb_nxt;
      p0_r   <= p0_nxt;
      p1_r   <= p1_nxt;
      s2_r   <= s2_nxt;
      prod_r <= NN_W'(p0_r) + (NN_W'(p1_r) << 17);
      side_r <= s2_r;
    end
  end
endmodule

// ===== hw/rtl/csv_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
// Depends on csv_pkg.
module csv_sqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [csv_pkg::NN_W-1:0]      n,
  input  csv_pkg::side_t                side_in,
  output logic [csv_pkg::ROOT_W-1:0]    root,
  output csv_pkg::side_t                side_out
);
  import csv_pkg::*;

  logic [NN_W-1:0]   n_r    [SQRT_STEPS];
  logic [REM_W-1:0]  rem_r  [SQRT_STEPS];
  logic [ROOT_W-1:0] root_r [SQRT_STEPS];
  side_t             side_r [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_stage
    logic [NN_W-1:0]   n_in;
    logic [REM_W-1:0]  rem_in, rem2, trial;
    logic [ROOT_W-1:0] root_in;
    side_t             side_i;
    logic              ge;

    if (k == 0) begin : g_first
      assign n_in    = n;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_i  = side_in;
    end else begin : g_next
      assign n_in    = n_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_i  = side_r[k-1];
    end

    // bring down the next two bits, try root*4+1
    always_comb begin
      rem2  = {rem_in[REM_W-3:0], n_in[NN_W-1 -: 2]};
      trial = {root_in, 2'b01};
      ge    = rem2 >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k]    <= n_in << 2;
        rem_r[k]  <= ge ? rem2 - trial : rem2;
        root_r[k] <= {root_in[ROOT_W-2:0], ge};
        side_r[k] <= side_i;
      end
    end
  end

  assign root     = root_r[SQRT_STEPS-1];
  assign side_out = side_r[SQRT_STEPS-1];
endmodule

// ===== hw/rtl/csv_div.sv =====
// Pipelined restoring divide of |dot|<<14 by the root, then clamp and sign.
// Depends on csv_pkg. Last stage is the output register.
module csv_div (
  input  logic                             clk,
  input  logic                             en,
  input  logic [csv_pkg::ROOT_W-1:0]       root,
  input  csv_pkg::side_t                   side_in,
  output logic signed [csv_pkg::COS_W-1:0] cosine_r,
  output logic                             zero_r
);
  import csv_pkg::*;

  logic [NUM_W-1:0]  rem_r [DIV_STEPS];
  logic [ROOT_W-1:0] den_r [DIV_STEPS];
  logic [QUO_W-1:0]  q_r   [DIV_STEPS];
  side_t             sd_r  [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_stage
    localparam int SH = DIV_STEPS - 1 - j;
    logic [NUM_W-1:0]   rem_in;
    logic [ROOT_W-1:0]  den_in;
    logic [QUO_W-1:0]   q_in;
    side_t              sd_in;
    logic [NUM_W+1:0]   dsh;
    logic               ge;

    if (j == 0) begin : g_first
      assign rem_in = {side_in.mag, 14'b0};
      assign den_in = root;
      assign q_in   = '0;
      assign sd_in  = side_in;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign den_in = den_r[j-1];
      assign q_in   = q_r[j-1];
      assign sd_in  = sd_r[j-1];
    end

    always_comb begin
      dsh = (NUM_W+2)'(den_in) << SH;
      ge  = (NUM_W+2)'(rem_in) >= dsh;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? rem_in - dsh[NUM_W-1:0] : rem_in;
        den_r[j] <= den_in;
        q_r[j]   <= {q_in[QUO_W-2:0], ge};
        sd_r[j]  <= sd_in;
      end
    end
  end

  logic [QUO_W-1:0]        q_sat;
  logic signed [COS_W-1:0] cos_nxt;
  side_t                   sd_last;

  always_comb begin
    sd_last = sd_r[DIV_STEPS-1];
    q_sat   = (q_r[DIV_STEPS-1] > COS_ONE) ? COS_ONE : q_r[DIV_STEPS-1];
    if (sd_last.zero) begin
      cos_nxt = '0;
    end else if (sd_last.neg) begin
      cos_nxt = -$signed(q_sat);
    end else begin
      cos_nxt = $signed(q_sat);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cosine_r <= cos_nxt;
      zero_r   <= sd_last.zero;
    end
  end
endmodule

// ===== hw/rtl/cosine_similarity_vec4_unit.sv =====
// Top level of the cosine similarity unit: lanes, norm merge, root, divide.
// Depends on csv_pkg, csv_lane, csv_norm, csv_sqrt, csv_div and the defines header.
//
//  channel | dir | tdata                        | tuser
//  in_     | in  | a_x a_y a_z a_w b_x..b_w x16 | -
//  out_    | out | cosine (Q1.14)               | zero_vector
//
// One item per cycle while the output is not stalled; items pass the lanes, the
// norm merge, the 33-stage root and 16-stage divide pipelines and the output register.
// Reset clears only the valid pipeline; no state survives between items.
// A stalled output stalls the whole pipeline; in_tready follows that enable.
`include "cosine_similarity_vec4_unit_defines.svh"

module cosine_similarity_vec4_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [15:0]  out_tdata,  // cosine
  output logic [0:0]   out_tuser   // zero_vector
);
  import csv_pkg::*;

  logic                    en;
  logic [LATENCY-1:0]      vld_r, vld_nxt;
  lane_t                   lanes [LANES];
  logic [NN_W-1:0]         prod;
  side_t                   side_n, side_s;
  logic [ROOT_W-1:0]       root;
  logic signed [COS_W-1:0] cosine_r;
  logic                    zero_r;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    csv_lane u_lane (
      .clk    (clk),
      .en     (en),
      .a      ($signed(in_tdata[i*ELEM_W +: ELEM_W])),
      .b      ($signed(in_tdata[(i+LANES)*ELEM_W +: ELEM_W])),
      .lane_r (lanes[i])
    );
  end

  csv_norm u_norm (
    .clk    (clk),
    .en     (en),
    .lanes  (lanes),
    .prod_r (prod),
    .side_r (side_n)
  );

  csv_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .n        (prod),
    .side_in  (side_n),
    .root     (root),
    .side_out (side_s)
  );

  csv_div u_div (
    .clk      (clk),
    .en       (en),
    .root     (root),
    .side_in  (side_s),
    .cosine_r (cosine_r),
    .zero_r   (zero_r)
  );

  assign vld_nxt = {vld_r[LATENCY-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  assign out_tvalid = vld_r[LATENCY-1];
  assign out_tdata  = cosine_r;
  assign out_tuser  = zero_r;

  `CSV_ASSERT_IMPL(a_zero_cos, out_tvalid && out_tuser[0], out_tdata == 16'd0)
  `CSV_ASSERT_IMPL(a_cos_range, out_tvalid, cosine_r <= 16384 && cosine_r >= -16384)
  `CSV_ASSERT_ALWAYS(a_ready_idle, out_tvalid || in_tready)
endmodule
